// ===== rtl/esc_pkg.sv =====
// Shared types, codes and character helpers for the JSON string escaper.
// Used by esc_front, esc_queue, esc_back and json_string_escaper_unit.
package esc_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_LIT  = 3'd1;
   localparam logic [2:0] KIND_ESC2 = 3'd2;
   localparam logic [2:0] KIND_U00  = 3'd3;
   localparam logic [2:0] KIND_BAD  = 3'd4;
   localparam logic [2:0] KIND_SEQ  = 3'd5;

   typedef struct packed {
      logic [1:0]      nbad;
      logic [2:0]      kind;
      logic [7:0]      data;
      logic [1:0]      seq_len;
      logic [2:0][7:0] seq;
   } cmd_type;

   function automatic logic [7:0] bad_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h5C;
         3'd1:    ch = 8'h75;
         3'd2:    ch = 8'h66;
         3'd3:    ch = 8'h66;
         3'd4:    ch = 8'h66;
         default: ch = 8'h64;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 4'd10) ch = 8'h30 + {4'd0, v};
      else ch = 8'h61 + {4'd0, v} - 8'd10;
      return ch;
   endfunction

   function automatic logic [2:0] body_len(input logic [2:0] kind, input logic [1:0] seq_len);
      logic [2:0] len;
      case (kind)
         KIND_LIT:  len = 3'd1;
         KIND_ESC2: len = 3'd2;
         KIND_U00:  len = 3'd6;
         KIND_BAD:  len = 3'd6;
         KIND_SEQ:  len = {1'b0, seq_len} + 3'd1;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/json_string_escaper_unit.sv =====
// Top level of the JSON string escaper with UTF-8 validation.
// Instantiates esc_front, esc_queue and esc_back; depends on esc_pkg.
//
// One source byte enters per transfer and the escaped string body leaves one
// byte per transfer, with rsp_run_last marking the final byte caused by each
// input byte. The back end emits one output byte per cycle while rsp_stall is
// low; an input byte that yields n output bytes (0 to 24) holds it until all n
// are sent, so unstalled plain text runs at one byte per cycle while escapes
// and replacement sequences slow the input to match. A queue of QUEUE_DEPTH
// commands lets the front keep taking bytes while the back works through
// longer expansions. There is no start-up pass after reset.
module json_string_escaper_unit #(
   parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic             accept;
   logic             push;
   logic             pop;
   logic             full;
   logic             head_valid;
   esc_pkg::cmd_type push_cmd;
   esc_pkg::cmd_type head_cmd;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   esc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .cmd     (push_cmd)
   );

   esc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   esc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// ===== rtl/esc_front.sv =====
// Front end: tracks pending UTF-8 sequences and classifies each input byte
// into at most one output command. Depends on esc_pkg.
module esc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   output logic                push,
   output esc_pkg::cmd_type    cmd
);

   logic [7:0] held_ff [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] need_ff, need_in;

   logic       is_cont;
   logic [2:0] fresh_kind;
   logic [7:0] fresh_data;
   logic [1:0] fresh_need;
   logic       do_fresh;
   logic       store_cont;

   always_comb begin
      fresh_need = 2'd0;
      fresh_data = in_byte;
      case (in_byte)
         8'h22: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h22; end
         8'h5C: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h5C; end
         8'h0A: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h6E; end
         8'h0D: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h72; end
         8'h09: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h74; end
         8'h08: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h62; end
         8'h0C: begin fresh_kind = esc_pkg::KIND_ESC2; fresh_data = 8'h66; end
         default: begin
            if (in_byte < 8'h20) begin
               fresh_kind = esc_pkg::KIND_U00;
            end else if (in_byte < 8'h80) begin
               fresh_kind = esc_pkg::KIND_LIT;
            end else if ((in_byte & 8'hE0) == 8'hC0) begin
               fresh_kind = esc_pkg::KIND_NONE;
               fresh_need = 2'd1;
            end else if ((in_byte & 8'hF0) == 8'hE0) begin
               fresh_kind = esc_pkg::KIND_NONE;
               fresh_need = 2'd2;
            end else if ((in_byte & 8'hF8) == 8'hF0) begin
               fresh_kind = esc_pkg::KIND_NONE;
               fresh_need = 2'd3;
            end else begin
               fresh_kind = esc_pkg::KIND_BAD;
            end
         end
      endcase
   end

   assign is_cont = (in_byte[7:6] == 2'b10);

   always_comb begin
      cmd.nbad      = 2'd0;
      cmd.kind      = esc_pkg::KIND_NONE;
      cmd.data      = fresh_data;
      cmd.seq_len   = held_count_ff;
      cmd.seq[0]    = held_ff[0];
      cmd.seq[1]    = held_ff[1];
      cmd.seq[2]    = held_ff[2];
      held_count_in = held_count_ff;
      need_in       = need_ff;
      do_fresh      = 1'b0;
      store_cont    = 1'b0;
      if (held_count_ff != 2'd0) begin
         if (is_cont) begin
            if (held_count_ff >= need_ff) begin
               cmd.kind      = esc_pkg::KIND_SEQ;
               cmd.data      = in_byte;
               held_count_in = 2'd0;
               need_in       = 2'd0;
            end else begin
               store_cont    = 1'b1;
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            cmd.nbad      = held_count_ff;
            held_count_in = 2'd0;
            need_in       = 2'd0;
            do_fresh      = (in_byte != 8'd0);
         end
      end else begin
         do_fresh = (in_byte != 8'd0);
      end
      if (do_fresh) begin
         cmd.kind = fresh_kind;
         if (fresh_need != 2'd0) begin
            held_count_in = 2'd1;
            need_in       = fresh_need;
         end
      end
   end

   assign push = accept && ((cmd.nbad != 2'd0) || (cmd.kind != esc_pkg::KIND_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         need_ff       <= 2'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         need_ff       <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (do_fresh && (fresh_need != 2'd0)) begin
            held_ff[0] <= in_byte;
         end else if (store_cont) begin
            case (held_count_ff)
               2'd1:    held_ff[1] <= in_byte;
               default: held_ff[2] <= in_byte;
            endcase
         end
      end
   end

endmodule

// ===== rtl/esc_queue.sv =====
// Short command queue between front and back ends.
// Depends on esc_pkg.
module esc_queue #(
   parameter int DEPTH = esc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  esc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output esc_pkg::cmd_type head_cmd
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   esc_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/esc_back.sv =====
// Back end: expands queued commands into output bytes, one per cycle while
// rsp_stall is low, into a registered output stage. Depends on esc_pkg.
module esc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  esc_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last
);

   logic [1:0] bad_idx_ff;
   logic [2:0] pos_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   logic       advance;
   logic       in_bad;
   logic [2:0] len;
   logic [7:0] cur_byte;
   logic       cmd_last;

   assign advance = head_valid && (!valid_ff || !rsp_stall);
   assign in_bad  = (bad_idx_ff != head_cmd.nbad);
   assign len     = esc_pkg::body_len(head_cmd.kind, head_cmd.seq_len);

   always_comb begin
      cur_byte = head_cmd.data;
      if (in_bad) begin
         cur_byte = esc_pkg::bad_char(pos_ff);
         cmd_last = (pos_ff == 3'd5) && (bad_idx_ff + 2'd1 == head_cmd.nbad) &&
                    (head_cmd.kind == esc_pkg::KIND_NONE);
      end else begin
         cmd_last = (pos_ff == len - 3'd1);
         case (head_cmd.kind)
            esc_pkg::KIND_ESC2: cur_byte = (pos_ff == 3'd0) ? 8'h5C : head_cmd.data;
            esc_pkg::KIND_U00: begin
               case (pos_ff)
                  3'd0:    cur_byte = 8'h5C;
                  3'd1:    cur_byte = 8'h75;
                  3'd2:    cur_byte = 8'h30;
                  3'd3:    cur_byte = 8'h30;
                  3'd4:    cur_byte = esc_pkg::hex_char(head_cmd.data[7:4]);
                  default: cur_byte = esc_pkg::hex_char(head_cmd.data[3:0]);
               endcase
            end
            esc_pkg::KIND_BAD: cur_byte = esc_pkg::bad_char(pos_ff);
            esc_pkg::KIND_SEQ: begin
               if (pos_ff < {1'b0, head_cmd.seq_len}) begin
                  case (pos_ff[1:0])
                     2'd0:    cur_byte = head_cmd.seq[0];
                     2'd1:    cur_byte = head_cmd.seq[1];
                     default: cur_byte = head_cmd.seq[2];
                  endcase
               end
            end
            default: cur_byte = head_cmd.data;
         endcase
      end
   end

   assign pop = advance && cmd_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_idx_ff <= 2'd0;
         pos_ff     <= 3'd0;
         valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            if (cmd_last) begin
               bad_idx_ff <= 2'd0;
               pos_ff     <= 3'd0;
            end else if (in_bad && (pos_ff == 3'd5)) begin
               bad_idx_ff <= bad_idx_ff + 2'd1;
               pos_ff     <= 3'd0;
            end else begin
               pos_ff <= pos_ff + 3'd1;
            end
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= cur_byte;
         last_ff <= cmd_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

endmodule

// ===== bench/esc_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for json_string_escaper_unit: watches the source and escaped-byte
// transfers, predicts the escaped stream and compares it byte by byte.
// Depends only on the block's port list; no package is needed.
module esc_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   input  logic       drain_done,
   output int         fail_count,
   output int         open_count,
   output int         bytes_checked
);

   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_D      = 8'h64;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_HIGH   = 8'h80;
   localparam int         PRINT_CAP = 40;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } esc_beat_t;

   esc_beat_t   expected_q[$];
   logic [7:0]  burst_q[$];
   logic [7:0]  utf_held [3];
   int unsigned utf_held_n;
   int unsigned utf_need_n;
   bit          leftover_flagged;

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) $display("esc_scoreboard @%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? CH_ZERO + {4'd0, v} : CH_A + {4'd0, v} - 8'd10;
   endfunction

   function automatic void push_pair(input logic [7:0] second);
      burst_q.push_back(CH_BSLASH);
      burst_q.push_back(second);
   endfunction

   function automatic void push_replacement();
      push_pair(CH_U);
      burst_q.push_back(CH_F);
      burst_q.push_back(CH_F);
      burst_q.push_back(CH_F);
      burst_q.push_back(CH_D);
   endfunction

   function automatic void start_sequence(input logic [7:0] lead, input int unsigned need);
      utf_held[0] = lead;
      utf_held_n  = 1;
      utf_need_n  = need;
   endfunction

   function automatic void escape_fresh(input logic [7:0] c);
      case (c)
         CH_QUOTE:  push_pair(CH_QUOTE);
         CH_BSLASH: push_pair(CH_BSLASH);
         CH_LF:     push_pair(CH_N);
         CH_CR:     push_pair(CH_R);
         CH_TAB:    push_pair(CH_T);
         CH_BS:     push_pair(CH_B);
         CH_FF:     push_pair(CH_F);
         default: begin
            if (c < CH_SPACE) begin
               push_pair(CH_U);
               burst_q.push_back(CH_ZERO);
               burst_q.push_back(CH_ZERO);
               burst_q.push_back(hex_digit(c[7:4]));
               burst_q.push_back(hex_digit(c[3:0]));
            end else if (c < CH_HIGH) begin
               burst_q.push_back(c);
            end else if (c[7:5] == 3'b110) begin
               start_sequence(c, 1);
            end else if (c[7:4] == 4'b1110) begin
               start_sequence(c, 2);
            end else if (c[7:3] == 5'b11110) begin
               start_sequence(c, 3);
            end else begin
               push_replacement();
            end
         end
      endcase
   endfunction

   function automatic void predict_escape(input logic [7:0] c);
      burst_q.delete();
      if (utf_held_n > 0) begin
         if (c != CH_END && c[7:6] == 2'b10) begin
            if (utf_held_n >= utf_need_n) begin
               for (int k = 0; k < utf_held_n; k++) burst_q.push_back(utf_held[k]);
               burst_q.push_back(c);
               utf_held_n = 0;
               utf_need_n = 0;
            end else begin
               utf_held[utf_held_n] = c;
               utf_held_n++;
            end
         end else begin
            repeat (utf_held_n) push_replacement();
            utf_held_n = 0;
            utf_need_n = 0;
            if (c != CH_END) escape_fresh(c);
         end
      end else if (c != CH_END) begin
         escape_fresh(c);
      end
      foreach (burst_q[k])
         expected_q.push_back('{ch: burst_q[k], last: (k == burst_q.size() - 1)});
   endfunction

   always @(posedge clock) begin
      esc_beat_t want;
      if (reset) begin
         expected_q.delete();
         utf_held_n       = 0;
         utf_need_n       = 0;
         leftover_flagged = 0;
         fail_count       = 0;
         bytes_checked    = 0;
      end else begin
         if (req_valid && !req_stall) predict_escape(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            bytes_checked++;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b", rsp_out_byte,
                                         rsp_run_last));
            end else begin
               want = expected_q.pop_front();
               if (rsp_out_byte !== want.ch || rsp_run_last !== want.last)
                  report_mismatch($sformatf("got byte %h last %b, wanted byte %h last %b",
                                            rsp_out_byte, rsp_run_last, want.ch, want.last));
            end
         end
         if (drain_done && !leftover_flagged && expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d escaped bytes never arrived", expected_q.size()));
            leftover_flagged = 1;
         end
      end
      open_count = expected_q.size();
   end

endmodule

// ===== bench/tb_json_string_escaper_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for json_string_escaper_unit: drives source bytes and output
// stall with random idling and gives the verdict.
// Depends on esc_scoreboard and the block's RTL.
module tb_json_string_escaper_unit;

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_ITEMS   = 125;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUIET_FIRST    = 90;
   localparam int QUIET_LAST     = 120;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       drain_done  = 1'b0;

   int         fail_count;
   int         open_count;
   int         bytes_checked;
   int         items_sent  = 0;
   int         idle_cycles = 0;
   int         stall_left  = 0;
   bit         quiet       = 1'b0;
   logic [7:0] directed_bytes [DIRECTED_COUNT];

   json_string_escaper_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   esc_scoreboard scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .drain_done    (drain_done),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .bytes_checked (bytes_checked)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap(input bit hush);
      int roll;
      roll = $urandom_range(0, 99);
      if (hush || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] lead_for(input int len);
      case (len)
         2:       return 8'($urandom_range(8'hC0, 8'hDF));
         3:       return 8'($urandom_range(8'hE0, 8'hEF));
         default: return 8'($urandom_range(8'hF0, 8'hF7));
      endcase
   endfunction

   function automatic logic [7:0] continuation();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_gap(quiet);
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int         roll;
      int         len;
      logic [7:0] breaker;
      directed_bytes = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C,
                         8'h01, 8'h1F, 8'h7F,
                         8'hC3, 8'hA9,
                         8'hF0, 8'h9F, 8'h98, 8'h80,
                         8'h80, 8'hF8,
                         8'hF0, 8'h90, 8'h80, 8'hFF,
                         8'hC0, 8'h00,
                         8'h00};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[k]) send_byte(directed_bytes[k]);

      while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         quiet = (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
         roll  = $urandom_range(0, 99);
         if (roll < 35) begin
            send_byte(8'($urandom_range(8'h20, 8'h7F)));
         end else if (roll < 45) begin
            send_byte(8'($urandom_range(8'h01, 8'h1F)));
         end else if (roll < 52) begin
            send_byte(directed_bytes[$urandom_range(0, 6)]);
         end else if (roll < 80) begin
            len = $urandom_range(2, 4);
            send_byte(lead_for(len));
            repeat (len - 1) send_byte(continuation());
         end else if (roll < 90) begin
            len = $urandom_range(2, 4);
            send_byte(lead_for(len));
            repeat ($urandom_range(0, len - 2)) send_byte(continuation());
            do breaker = 8'($urandom_range(0, 255)); while (breaker[7:6] == 2'b10);
            send_byte(breaker);
         end else if (roll < 96) begin
            send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
         end else begin
            send_byte(8'h00);
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Sent %0d source bytes (escapes, controls, UTF-8 runs, broken and stray bytes)",
               items_sent);
      $display("Checked %0d escaped bytes under random idling on both channels", bytes_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
